FILE: rtl/core/dftc_pkg.sv
// Shared widths, operation codes and helpers for the drop-frame timecode counter.
package dftc_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned FRAME_W  = 6;
    localparam int unsigned REP_W    = 8;
    localparam int unsigned FPS_W    = 6;

    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BACK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd3;

    localparam logic [FPS_W-1:0]    FPS_RESET   = 6'd30;
    localparam logic [FPS_W-1:0]    FPS_DROP30  = 6'd30;
    localparam logic [FPS_W-1:0]    FPS_DROP60  = 6'd60;
    localparam logic [FRAME_W-1:0]  DROP_N30    = 6'd2;
    localparam logic [FRAME_W-1:0]  DROP_N60    = 6'd4;
    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;    // request accepted this cycle
        logic back;     // take one backward frame step
        logic capture;  // load the result register
    } dftc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_back;  // incoming request is a step back with a nonzero count
        logic last_step;   // one backward step left
    } dftc_status_t;

    // True when the minute value is a multiple of ten
    function automatic logic minute_mult10(input logic [MINUTE_W-1:0] m);
        logic r;
        begin
            case (m) inside
                6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/dftc_req_if.sv
// Request channel: operation and timecode operands.
interface dftc_req_if
    import dftc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [HOUR_W-1:0]   hour_in;
    logic [MINUTE_W-1:0] minute_in;
    logic [SECOND_W-1:0] second_in;
    logic [FRAME_W-1:0]  frame_in;
    logic [REP_W-1:0]    repeat_count;

    modport source (
        output valid, func, hour_in, minute_in, second_in, frame_in, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, func, hour_in, minute_in, second_in, frame_in, repeat_count,
        output ready
    );
endinterface

FILE: rtl/core/dftc_rsp_if.sv
// Response channel: stored timecode and compare flag.
interface dftc_rsp_if
    import dftc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [FRAME_W-1:0]  frame_out;
    logic                is_equal;

    modport source (
        output valid, hour_out, minute_out, second_out, frame_out, is_equal,
        input  ready
    );
    modport sink (
        input  valid, hour_out, minute_out, second_out, frame_out, is_equal,
        output ready
    );
endinterface

FILE: rtl/core/dftc_ctrl.sv
// Controller state machine: request intake, backward step loop, result handoff.
module dftc_ctrl
    import dftc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  dftc_status_t status,
    output dftc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BACK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // Take a new request only when the result register is free or draining
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.needs_back ? ST_BACK : ST_FINISH;
                end
            end
            ST_BACK:
            begin
                cmd.back = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.capture    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/dftc_datapath.sv
// Datapath: timecode counters, frame rate register, step logic and result register.
module dftc_datapath
    import dftc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [FPS_W-1:0]    cfg_wdata,
    input  logic [FUNC_W-1:0]   func,
    input  logic [HOUR_W-1:0]   hour_in,
    input  logic [MINUTE_W-1:0] minute_in,
    input  logic [SECOND_W-1:0] second_in,
    input  logic [FRAME_W-1:0]  frame_in,
    input  logic [REP_W-1:0]    repeat_count,
    input  dftc_cmd_t           cmd,
    output dftc_status_t        status,
    output logic [HOUR_W-1:0]   hour_out,
    output logic [MINUTE_W-1:0] minute_out,
    output logic [SECOND_W-1:0] second_out,
    output logic [FRAME_W-1:0]  frame_out,
    output logic                is_equal
);

    logic [FPS_W-1:0]    fps_reg;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [SECOND_W-1:0] second_reg, second_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [REP_W-1:0]    rep_reg, rep_next;
    logic                eq_reg, eq_next;

    logic [HOUR_W-1:0]   hour_o_reg;
    logic [MINUTE_W-1:0] minute_o_reg;
    logic [SECOND_W-1:0] second_o_reg;
    logic [FRAME_W-1:0]  frame_o_reg;
    logic                eq_o_reg;

    logic [FPS_W-1:0]   fps_eff;
    logic [FRAME_W-1:0] drop_n;
    logic               match;

    // Advance results
    logic [HOUR_W-1:0]   adv_hour;
    logic [MINUTE_W-1:0] adv_minute;
    logic [SECOND_W-1:0] adv_second;
    logic [FRAME_W-1:0]  adv_frame;
    logic [FRAME_W:0]    frame_inc;
    logic [SECOND_W:0]   second_inc;
    logic [MINUTE_W:0]   minute_inc;
    logic [HOUR_W:0]     hour_inc;

    // Backward step results
    logic [HOUR_W-1:0]   bk_hour;
    logic [MINUTE_W-1:0] bk_minute;
    logic [SECOND_W-1:0] bk_second;
    logic [FRAME_W-1:0]  bk_frame;
    logic                at_start;

    assign fps_eff = (fps_reg == '0) ? FPS_W'(1) : fps_reg;

    always_comb
    begin
        if (fps_reg == FPS_DROP30)
        begin
            drop_n = DROP_N30;
        end
        else if (fps_reg == FPS_DROP60)
        begin
            drop_n = DROP_N60;
        end
        else
        begin
            drop_n = '0;
        end
    end

    assign match = (hour_in == hour_reg) && (minute_in == minute_reg) &&
                   (second_in == second_reg) && (frame_in == frame_reg);

    assign frame_inc  = {1'b0, frame_reg} + 7'd1;
    assign second_inc = {1'b0, second_reg} + 7'd1;
    assign minute_inc = {1'b0, minute_reg} + 7'd1;
    assign hour_inc   = {1'b0, hour_reg} + 6'd1;

    always_comb
    begin
        adv_hour   = hour_reg;
        adv_minute = minute_reg;
        adv_second = second_reg;
        adv_frame  = '0;
        if (frame_inc < {1'b0, fps_eff})
        begin
            adv_frame = frame_inc[FRAME_W-1:0];
        end
        else if (second_inc < {1'b0, SECOND_LAST} + 7'd1)
        begin
            adv_second = second_inc[SECOND_W-1:0];
        end
        else if (minute_inc < {1'b0, MINUTE_LAST} + 7'd1)
        begin
            adv_second = '0;
            adv_minute = minute_inc[MINUTE_W-1:0];
            // Skip the dropped frame numbers entering a minute not divisible by ten
            if (drop_n != '0 && !minute_mult10(minute_inc[MINUTE_W-1:0]))
            begin
                adv_frame = drop_n;
            end
        end
        else
        begin
            adv_second = '0;
            adv_minute = '0;
            adv_hour   = (hour_inc < {1'b0, HOUR_LAST} + 6'd1) ? hour_inc[HOUR_W-1:0] : '0;
        end
    end

    assign at_start = (frame_reg == '0) ||
                      (drop_n != '0 && frame_reg == drop_n && !minute_mult10(minute_reg));

    always_comb
    begin
        bk_hour   = hour_reg;
        bk_minute = minute_reg;
        bk_second = second_reg;
        bk_frame  = frame_reg - FRAME_W'(1);
        if (at_start)
        begin
            bk_frame = fps_eff - FRAME_W'(1);
            if (second_reg != '0)
            begin
                bk_second = second_reg - SECOND_W'(1);
            end
            else
            begin
                bk_second = SECOND_LAST;
                if (minute_reg != '0)
                begin
                    bk_minute = minute_reg - MINUTE_W'(1);
                end
                else
                begin
                    bk_minute = MINUTE_LAST;
                    bk_hour   = (hour_reg != '0) ? hour_reg - HOUR_W'(1) : HOUR_LAST;
                end
            end
        end
    end

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        frame_next  = frame_reg;
        rep_next    = rep_reg;
        eq_next     = eq_reg;
        if (cmd.start)
        begin
            rep_next = repeat_count;
            eq_next  = (func == FUNC_COMPARE) && match;
            case (func)
                FUNC_ADVANCE:
                begin
                    hour_next   = adv_hour;
                    minute_next = adv_minute;
                    second_next = adv_second;
                    frame_next  = adv_frame;
                end
                FUNC_LOAD:
                begin
                    hour_next   = hour_in;
                    minute_next = minute_in;
                    second_next = second_in;
                    frame_next  = frame_in;
                end
                default:
                begin
                    // step back runs in the loop; compare holds the counters
                end
            endcase
        end
        else if (cmd.back)
        begin
            hour_next   = bk_hour;
            minute_next = bk_minute;
            second_next = bk_second;
            frame_next  = bk_frame;
            rep_next    = rep_reg - REP_W'(1);
        end
    end

    assign status.needs_back = (func == FUNC_BACK) && (repeat_count != '0);
    assign status.last_step  = (rep_reg == REP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg    <= FPS_RESET;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            frame_reg  <= '0;
            rep_reg    <= '0;
            eq_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fps_reg <= cfg_wdata;
            end
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            frame_reg  <= frame_next;
            rep_reg    <= rep_next;
            eq_reg     <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hour_o_reg   <= hour_reg;
            minute_o_reg <= minute_reg;
            second_o_reg <= second_reg;
            frame_o_reg  <= frame_reg;
            eq_o_reg     <= eq_reg;
        end
    end

    assign hour_out   = hour_o_reg;
    assign minute_out = minute_o_reg;
    assign second_out = second_o_reg;
    assign frame_out  = frame_o_reg;
    assign is_equal   = eq_o_reg;

endmodule

FILE: rtl/core/drop_frame_timecode_counter_core.sv
// Top level of the drop-frame timecode counter: controller plus datapath.
//
// Requests arrive on req (valid/ready) and carry an operation: advance one
// frame, step back repeat_count frames, load a timecode, or compare a
// timecode with the stored one. Every request yields exactly one response on
// rsp with the stored timecode after the operation and the compare flag.
// Frame rate: cfg_we/cfg_wdata, written by the user only while the block is idle
// (not enforced by the block); 30 and 60 select drop-frame numbering.
//
// Sequencing: advance, load and compare pass from idle to the finish state,
// which loads the result register; step back with a nonzero count first passes
// through the back state, running the single step unit once per backward frame.
// One request is in flight at a time.
// Reset clears the timecode to 00:00:00:00 and sets the frame rate to 30.
// The response sits in an output register; a new request is accepted while
// that response is being taken. If the receiver stalls, the response holds
// and req.ready stays low until the response is taken.
module drop_frame_timecode_counter_core
    import dftc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [FPS_W-1:0] cfg_wdata,
    dftc_req_if.sink         req,
    dftc_rsp_if.source       rsp
);

    dftc_cmd_t    cmd;
    dftc_status_t status;

    dftc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dftc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (req.func),
        .hour_in      (req.hour_in),
        .minute_in    (req.minute_in),
        .second_in    (req.second_in),
        .frame_in     (req.frame_in),
        .repeat_count (req.repeat_count),
        .cmd          (cmd),
        .status       (status),
        .hour_out     (rsp.hour_out),
        .minute_out   (rsp.minute_out),
        .second_out   (rsp.second_out),
        .frame_out    (rsp.frame_out),
        .is_equal     (rsp.is_equal)
    );

endmodule

FILE: tb/sv/tb_drop_frame_timecode_counter_core.sv
// Self-checking testbench for the drop-frame timecode counter: directed cases, then random traffic.
module tb_drop_frame_timecode_counter_core;
    import dftc_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [FRAME_W-1:0]  frame;
        logic [REP_W-1:0]    steps;
    } tc_request_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [FRAME_W-1:0]  frame;
        logic                is_equal;
    } tc_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [FPS_W-1:0] cfg_wdata;

    dftc_req_if req_ch ();
    dftc_rsp_if rsp_ch ();

    drop_frame_timecode_counter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Predicted timecode and frame rate
    logic [HOUR_W-1:0]   model_hour;
    logic [MINUTE_W-1:0] model_minute;
    logic [SECOND_W-1:0] model_second;
    logic [FRAME_W-1:0]  model_frame;
    logic [FPS_W-1:0]    model_fps;

    tc_result_t expected_timecodes[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int requests_sent      = 0;
    int responses_checked  = 0;
    int equal_hits         = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int frame_rate();
        return (model_fps == 0) ? 1 : int'(model_fps);
    endfunction

    function automatic int dropped_frames();
        if (model_fps == FPS_DROP30)
            return int'(DROP_N30);
        if (model_fps == FPS_DROP60)
            return int'(DROP_N60);
        return 0;
    endfunction

    function automatic void advance_frame();
        if (int'(model_frame) + 1 < frame_rate())
        begin
            model_frame = model_frame + 1'b1;
            return;
        end
        model_frame = '0;
        if (int'(model_second) + 1 < 60)
        begin
            model_second = model_second + 1'b1;
            return;
        end
        model_second = '0;
        if (int'(model_minute) + 1 < 60)
        begin
            model_minute = model_minute + 1'b1;
            // skip the first frame numbers of a minute that is not a multiple of ten
            if (dropped_frames() != 0 && model_minute % 10 != 0)
                model_frame = FRAME_W'(dropped_frames());
            return;
        end
        model_minute = '0;
        model_hour = (int'(model_hour) + 1 < 24) ? model_hour + 1'b1 : '0;
    endfunction

    function automatic void back_frame();
        int   skip;
        logic at_start;
        skip = dropped_frames();
        at_start = (model_frame == 0) ||
                   (skip != 0 && int'(model_frame) == skip && model_minute % 10 != 0);
        if (!at_start)
        begin
            model_frame = model_frame - 1'b1;
            return;
        end
        model_frame = FRAME_W'(frame_rate() - 1);
        if (model_second != 0)
        begin
            model_second = model_second - 1'b1;
            return;
        end
        model_second = SECOND_LAST;
        if (model_minute != 0)
        begin
            model_minute = model_minute - 1'b1;
            return;
        end
        model_minute = MINUTE_LAST;
        model_hour = (model_hour != 0) ? model_hour - 1'b1 : HOUR_LAST;
    endfunction

    function automatic tc_result_t apply_operation(input tc_request_t r);
        tc_result_t res;
        res.is_equal = 1'b0;
        case (r.func)
            FUNC_ADVANCE: advance_frame();
            FUNC_BACK:
            begin
                for (int i = 0; i < int'(r.steps); i++)
                    back_frame();
            end
            FUNC_LOAD:
            begin
                model_hour   = r.hour;
                model_minute = r.minute;
                model_second = r.second;
                model_frame  = r.frame;
            end
            default:
            begin
                res.is_equal = (r.hour == model_hour && r.minute == model_minute &&
                                r.second == model_second && r.frame == model_frame);
            end
        endcase
        res.hour   = model_hour;
        res.minute = model_minute;
        res.second = model_second;
        res.frame  = model_frame;
        return res;
    endfunction

    // Leaves valid high after acceptance; the caller drives the next request or drops valid
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [HOUR_W-1:0] hour,
                                input logic [MINUTE_W-1:0] minute,
                                input logic [SECOND_W-1:0] second,
                                input logic [FRAME_W-1:0] frame, input logic [REP_W-1:0] steps);
        tc_request_t r;
        r = '{func, hour, minute, second, frame, steps};
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= r.func;
        req_ch.hour_in      <= r.hour;
        req_ch.minute_in    <= r.minute;
        req_ch.second_in    <= r.second;
        req_ch.frame_in     <= r.frame;
        req_ch.repeat_count <= r.steps;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_timecodes.push_back(apply_operation(r));
        requests_sent++;
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (expected_timecodes.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_frame_rate(input logic [FPS_W-1:0] fps);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= fps;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_fps = fps;
    endtask

    task automatic send_random_request();
        logic [REP_W-1:0] steps;
        steps = ($urandom_range(0, 1) == 0) ? REP_W'($urandom_range(0, 15))
                                             : REP_W'($urandom_range(0, 255));
        send_request(FUNC_W'($urandom_range(0, 3)), HOUR_W'($urandom()),
                     MINUTE_W'($urandom()), SECOND_W'($urandom()), FRAME_W'($urandom()), steps);
    endtask

    // Load a timecode close to a rollover, move around it, then compare
    task automatic run_boundary_sequence(inout int sent);
        int                  rate;
        int                  ops;
        int                  roll;
        int                  idx;
        logic [HOUR_W-1:0]   h;
        logic [MINUTE_W-1:0] m;
        logic [SECOND_W-1:0] s;
        logic [FRAME_W-1:0]  f;
        rate = frame_rate();
        h = ($urandom_range(0, 2) == 0) ? HOUR_LAST : HOUR_W'($urandom_range(0, 23));
        case ($urandom_range(0, 3))
            0: m = MINUTE_LAST;
            1: m = MINUTE_W'(10 * $urandom_range(0, 5) + 9);
            2: m = MINUTE_W'(10 * $urandom_range(0, 5));
            default: m = MINUTE_W'($urandom_range(0, 59));
        endcase
        s = ($urandom_range(0, 3) != 0) ? SECOND_LAST : SECOND_W'($urandom_range(0, 59));
        case ($urandom_range(0, 3))
            0, 1: f = FRAME_W'(rate - 1 - ((rate > 2) ? $urandom_range(0, 2) : 0));
            2: f = FRAME_W'(dropped_frames() + $urandom_range(0, 1));
            default: f = FRAME_W'($urandom_range(0, rate - 1));
        endcase
        send_request(FUNC_LOAD, h, m, s, f, REP_W'($urandom()));
        sent++;
        ops = $urandom_range(1, 6);
        repeat (ops)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_request(FUNC_ADVANCE, HOUR_W'($urandom()), MINUTE_W'($urandom()),
                             SECOND_W'($urandom()), FRAME_W'($urandom()), REP_W'($urandom()));
            else
                send_request(FUNC_BACK, HOUR_W'($urandom()), MINUTE_W'($urandom()),
                             SECOND_W'($urandom()), FRAME_W'($urandom()),
                             (roll < 90) ? REP_W'($urandom_range(0, 6))
                                         : REP_W'($urandom_range(0, 255)));
            sent++;
        end
        h = model_hour;
        m = model_minute;
        s = model_second;
        f = model_frame;
        // half the compares miss by one bit in one field
        if ($urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    idx = $urandom_range(0, HOUR_W - 1);
                    h[idx] = ~h[idx];
                end
                1:
                begin
                    idx = $urandom_range(0, MINUTE_W - 1);
                    m[idx] = ~m[idx];
                end
                2:
                begin
                    idx = $urandom_range(0, SECOND_W - 1);
                    s[idx] = ~s[idx];
                end
                default:
                begin
                    idx = $urandom_range(0, FRAME_W - 1);
                    f[idx] = ~f[idx];
                end
            endcase
        end
        send_request(FUNC_COMPARE, h, m, s, f, REP_W'($urandom()));
        sent++;
    endtask

    task automatic test_directed_operations();
        send_request(FUNC_COMPARE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        // borrow through every field back to the last frame of the day
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd2);
        send_request(FUNC_COMPARE, 5'd23, 6'd59, 6'd59, 6'd29, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_LOAD, 5'd0, 6'd0, 6'd59, 6'd29, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd1);
        // skipped frame number loaded, then step back across it
        send_request(FUNC_LOAD, 5'd0, 6'd1, 6'd0, 6'd1, 8'd0);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd3);
        // out-of-range values in every field
        send_request(FUNC_LOAD, 5'd31, 6'd63, 6'd63, 6'd63, 8'd0);
        send_request(FUNC_COMPARE, 5'd31, 6'd63, 6'd63, 6'd63, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_LOAD, 5'd31, 6'd63, 6'd63, 6'd63, 8'd0);
        send_request(FUNC_BACK, 5'd31, 6'd63, 6'd63, 6'd63, 8'd255);
    endtask

    task automatic test_frame_rate_extremes();
        set_frame_rate(FPS_DROP60);
        send_request(FUNC_LOAD, 5'd0, 6'd10, 6'd59, 6'd59, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd1);
        send_request(FUNC_LOAD, 5'd0, 6'd9, 6'd59, 6'd59, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        // a zero rate behaves as one frame per second
        set_frame_rate(6'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd1);
        set_frame_rate(6'd63);
        send_request(FUNC_LOAD, 5'd0, 6'd0, 6'd0, 6'd62, 8'd0);
        send_request(FUNC_ADVANCE, 5'd0, 6'd0, 6'd0, 6'd0, 8'd0);
        send_request(FUNC_COMPARE, 5'd0, 6'd0, 6'd0, 6'd62, 8'd0);
        set_frame_rate(6'd1);
        send_request(FUNC_BACK, 5'd0, 6'd0, 6'd0, 6'd0, 8'd1);
    endtask

    task automatic test_random_phase(input logic [FPS_W-1:0] fps, input int idle_pct,
                                     input int stall_pct, input int count);
        int sent;
        set_frame_rate(fps);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 75)
                run_boundary_sequence(sent);
            else
            begin
                send_random_request();
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        tc_result_t got;
        tc_result_t want;
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.hour_out, rsp_ch.minute_out, rsp_ch.second_out,
                    rsp_ch.frame_out, rsp_ch.is_equal};
            responses_checked++;
            if (expected_timecodes.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: response with none pending: %0d:%0d:%0d:%0d eq=%0b", $realtime,
                             got.hour, got.minute, got.second, got.frame, got.is_equal);
            end
            else
            begin
                want = expected_timecodes.pop_front();
                if (want.is_equal)
                    equal_hits++;
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: expected %0d:%0d:%0d:%0d eq=%0b, got %0d:%0d:%0d:%0d eq=%0b",
                                 $realtime, want.hour, want.minute, want.second, want.frame,
                                 want.is_equal, got.hour, got.minute, got.second, got.frame,
                                 got.is_equal);
                end
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= FUNC_ADVANCE;
        req_ch.hour_in       <= '0;
        req_ch.minute_in     <= '0;
        req_ch.second_in     <= '0;
        req_ch.frame_in      <= '0;
        req_ch.repeat_count  <= '0;
        model_fps    = FPS_RESET;
        model_hour   = '0;
        model_minute = '0;
        model_second = '0;
        model_frame  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_operations();
        test_frame_rate_extremes();
        test_random_phase(FPS_DROP30, 0, 0, 155);
        test_random_phase(FPS_DROP60, 77, 0, 155);
        test_random_phase(6'd25, 0, 77, 155);
        test_random_phase(FPS_DROP30, 8, 8, 155);
        test_random_phase(FPS_DROP60, 0, 0, 155);
        test_random_phase(FPS_W'($urandom_range(1, 63)), 8, 8, 155);
        test_random_phase(6'd63, 77, 0, 155);
        test_random_phase(FPS_DROP60, 0, 77, 155);

        drain_responses();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests (advance, step back, load, compare) at rates 0..63,",
                 requests_sent);
        $display("with drop-frame rollovers and four flow-control mixes; %0d checked, %0d hits.",
                 responses_checked, equal_hits);
        if (error_count == 0)
            $display("[drop_frame_timecode_counter_core] OK");
        else
            $display("[drop_frame_timecode_counter_core] ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[drop_frame_timecode_counter_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dftc_pkg.sv
rtl/core/dftc_req_if.sv
rtl/core/dftc_rsp_if.sv
rtl/core/dftc_ctrl.sv
rtl/core/dftc_datapath.sv
rtl/core/drop_frame_timecode_counter_core.sv
tb/sv/tb_drop_frame_timecode_counter_core.sv
